>>> sv/vicsek_flock_update_top_assert.svh
// ---------------------------------------------------------------------------
// Vicsek flock update assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef VICSEK_FLOCK_UPDATE_TOP_ASSERT_SVH
`define VICSEK_FLOCK_UPDATE_TOP_ASSERT_SVH

// The property must hold at every clock edge out of reset.
`define VFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vfu: assertion failed");

// The expression must never be true out of reset.
`define VFU_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("vfu: forbidden condition seen");

`endif

>>> sv/vfu_pkg.sv
// ---------------------------------------------------------------------------
// Vicsek flock update package
// Constants, types and the arctangent table shared by the flock update block.
// ---------------------------------------------------------------------------
package vfu_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int ADDR_W        = IDX_W + 1;
  localparam int CNT_W         = IDX_W + 1;
  localparam int POS_W         = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int CW            = 40;
  localparam int REM_W         = 17;
  localparam int REM_CW        = 5;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int MUL_AW        = 34;
  localparam int MUL_BW        = 18;
  localparam int MUL_PW        = MUL_AW + MUL_BW;

  localparam logic signed [CW-1:0] GAIN_Q30 = 40'sd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE    = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_SWAP   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_OUT, S_SELF_LAT, S_SELF_CS, S_MUL_X, S_WX_ST, S_WX,
    S_MUL_Y, S_WY_ST, S_WY, S_NB_CHK, S_NB_LAT, S_NB_DX, S_NB_DY, S_SQ_X,
    S_SQ_Y, S_NB_CS, S_NOISE, S_ATAN, S_WRITE
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] h;
  } particle_t;

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cord_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cord_rsp_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [REM_W-1:0] rem;
  } rem_rsp_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> sv/vfu_if.sv
// ---------------------------------------------------------------------------
// Vicsek flock update channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface vfu_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [vfu_pkg::IDX_W-1:0] index;
  logic [15:0]               pos_x;
  logic [15:0]               pos_y;
  logic signed [15:0]        heading;
  logic signed [15:0]        noise;

  modport source (output valid, cmd, index, pos_x, pos_y, heading, noise, input ready);
  modport sink (input valid, cmd, index, pos_x, pos_y, heading, noise, output ready);
endinterface

interface vfu_out_if;
  logic                      valid;
  logic                      ready;
  logic [15:0]               out_x;
  logic [15:0]               out_y;
  logic signed [15:0]        out_heading;
  logic [vfu_pkg::IDX_W-1:0] neighbour_count;
  logic                      status;

  modport source (output valid, out_x, out_y, out_heading, neighbour_count, status,
                  input ready);
  modport sink (input valid, out_x, out_y, out_heading, neighbour_count, status,
                output ready);
endinterface

>>> sv/vfu_mem.sv
// ---------------------------------------------------------------------------
// Vicsek flock update particle store
// Two banks of particles, one write port and one registered read port.
// ---------------------------------------------------------------------------
module vfu_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [vfu_pkg::ADDR_W-1:0] waddr_i,
  input  vfu_pkg::particle_t         wdata_i,
  input  logic [vfu_pkg::ADDR_W-1:0] raddr_i,
  output vfu_pkg::particle_t         rdata_o
);

  vfu_pkg::particle_t mem [2*vfu_pkg::MAX_PARTICLES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/vfu_cordic.sv
// ---------------------------------------------------------------------------
// Vicsek flock update CORDIC unit
// One iteration per cycle, rotation mode for sine and cosine, vectoring mode
// for the angle of a vector.
// ---------------------------------------------------------------------------
module vfu_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfu_pkg::cord_req_t  req_i,
  output vfu_pkg::cord_rsp_t  rsp_o
);

  localparam logic [vfu_pkg::STEP_W-1:0] LAST = vfu_pkg::STEP_W'(vfu_pkg::CORDIC_STEPS - 1);

  logic                          busy_q, done_q;
  logic [vfu_pkg::STEP_W-1:0]    step_q;
  logic signed [vfu_pkg::CW-1:0] x_q, y_q, x_d, y_d, sx, sy;
  logic [31:0]                   z_q, z_d, atn;
  logic                          vec_q, flip_q, zero_q, flip_d, zero_d, cw;

  always_comb begin
    sx  = x_q >>> step_q;
    sy  = y_q >>> step_q;
    atn = vfu_pkg::atan_entry(5'(step_q));
    cw  = vec_q ? ~y_q[vfu_pkg::CW-1] : z_q[31];
    flip_d = 1'b0;
    zero_d = 1'b0;
    if (req_i.start) begin
      if (req_i.vec) begin
        zero_d = (req_i.x == '0) && (req_i.y == '0);
        if (req_i.x[vfu_pkg::CW-1]) begin
          x_d = -req_i.x;
          y_d = -req_i.y;
          z_d = 32'h8000_0000;
        end else begin
          x_d = req_i.x;
          y_d = req_i.y;
          z_d = 32'h0;
        end
      end else begin
        flip_d = (req_i.z[31:30] == 2'b01) || (req_i.z[31:30] == 2'b10);
        x_d = vfu_pkg::GAIN_Q30;
        y_d = '0;
        z_d = flip_d ? req_i.z + 32'h8000_0000 : req_i.z;
      end
    end else if (cw) begin
      x_d = x_q + sy;
      y_d = y_q - sx;
      z_d = z_q + atn;
    end else begin
      x_d = x_q - sy;
      y_d = y_q + sx;
      z_d = z_q - atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start || busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (req_i.start) begin
      vec_q  <= req_i.vec;
      flip_q <= flip_d;
      zero_q <= zero_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.x    = flip_q ? -x_q : x_q;
  assign rsp_o.y    = flip_q ? -y_q : y_q;
  assign rsp_o.z    = zero_q ? 32'h0 : z_q;

endmodule

>>> sv/vfu_rem.sv
// ---------------------------------------------------------------------------
// Vicsek flock update remainder unit
// Restoring division, one quotient bit per cycle, remainder only.
// ---------------------------------------------------------------------------
module vfu_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfu_pkg::rem_req_t  req_i,
  output vfu_pkg::rem_rsp_t  rsp_o
);

  localparam logic [vfu_pkg::REM_CW-1:0] LAST = vfu_pkg::REM_CW'(vfu_pkg::REM_W - 1);

  logic                         busy_q, done_q;
  logic [vfu_pkg::REM_CW-1:0]   cnt_q;
  logic [vfu_pkg::REM_W-1:0]    dvd_q, div_q, r_q;
  logic [vfu_pkg::REM_W:0]      trial, r_next;

  always_comb begin
    trial  = {r_q, dvd_q[vfu_pkg::REM_W-1]};
    r_next = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[vfu_pkg::REM_W-2:0], 1'b0};
      r_q   <= r_next[vfu_pkg::REM_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

endmodule

>>> sv/vicsek_flock_update_top.sv
// ---------------------------------------------------------------------------
// Vicsek flock update top level
// Two-bank particle store with load, update, swap and read commands. An
// update moves one particle, averages the headings of its neighbors within
// the interaction radius and writes the result into the other bank.
// ---------------------------------------------------------------------------
//  Channel   Direction  Content
//  in_if     sink       cmd, index, pos_x, pos_y, heading, noise
//  out_if    source     out_x, out_y, out_heading, neighbour_count, status
//  cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// Load, swap and rejected items go straight to the output state; a read first
// passes through a registered store read. An update is paced by the shared
// remainder unit (one run per axis of the move and of each distance) and the
// CORDIC unit (one run per sine, cosine or angle).
// The block takes one item at a time; a result waits in the output register
// until taken. Reset sets bank select, state and settings, not data or store.
// ---------------------------------------------------------------------------
`include "vicsek_flock_update_top_assert.svh"

module vicsek_flock_update_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vfu_in_if.sink                        in_if,
  vfu_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [vfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vfu_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int IW = vfu_pkg::IDX_W;
  localparam int CW = vfu_pkg::CW;

  vfu_pkg::state_e state_q, state_d;

  logic [6:0]  pc_q;
  logic [15:0] box_q, speed_q, nscale_q;
  logic [31:0] radius_q;
  logic        bank_q;

  logic [IW-1:0]              idx_q;
  logic signed [15:0]         noise_q;
  logic [15:0]                px_q, py_q, nx_q, ny_q, nb_y_q, nb_h_q;
  logic signed [vfu_pkg::MUL_AW-1:0] c_q, s_q;
  logic signed [CW-1:0]       sumc_q, sums_q;
  logic [vfu_pkg::CNT_W-1:0]  cnt_q, j_q, n_eff;
  logic [vfu_pkg::REM_W-1:0]  dx_q, dy_q;
  logic                       sign_q;
  logic signed [vfu_pkg::MUL_PW-1:0] mul_q, prod;
  logic signed [vfu_pkg::MUL_AW-1:0] mul_a;
  logic signed [vfu_pkg::MUL_BW-1:0] mul_b;
  logic [31:0]                atan_z_q;

  logic [15:0]    o_x_q, o_y_q, o_h_q;
  logic [IW-1:0]  o_cnt_q;
  logic           o_st_q;

  logic accept, in_range, hit;
  vfu_pkg::particle_t rd_data, wr_data;
  logic [vfu_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  vfu_pkg::cord_req_t cord_req;
  vfu_pkg::cord_rsp_t cord_rsp;
  vfu_pkg::rem_req_t  rem_req;
  vfu_pkg::rem_rsp_t  rem_rsp;

  logic [vfu_pkg::REM_W-1:0] box_len, fold_d, axis_gap;
  logic signed [vfu_pkg::MUL_PW-1:0] mul_rnd;
  logic signed [17:0] pos_v, sval;
  logic signed [16:0] dnb;
  logic [15:0]        pos_base, newh;
  logic [31:0]        z_rnd;
  logic [32:0]        sq_sum;

  vfu_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  vfu_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .rsp_o  (cord_rsp)
  );

  vfu_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_comb begin
    n_eff    = (pc_q > 7'(vfu_pkg::MAX_PARTICLES)) ? 7'(vfu_pkg::MAX_PARTICLES) : pc_q;
    in_range = {1'b0, in_if.index} < n_eff;
    accept   = in_if.valid && in_if.ready;
    box_len  = (box_q == 16'd0) ? 17'h10000 : {1'b0, box_q};

    mul_rnd  = mul_q + 52'sd536870912;
    pos_base = (state_q == vfu_pkg::S_WY_ST) ? py_q : px_q;
    pos_v    = $signed({2'b00, pos_base}) + $signed(mul_rnd[47:30]);
    dnb      = (state_q == vfu_pkg::S_NB_LAT) ?
               $signed({1'b0, px_q}) - $signed({1'b0, rd_data.x}) :
               $signed({1'b0, py_q}) - $signed({1'b0, nb_y_q});
    sval     = ((state_q == vfu_pkg::S_WX_ST) || (state_q == vfu_pkg::S_WY_ST)) ?
               pos_v : 18'(dnb);

    fold_d   = (sign_q && (rem_rsp.rem != '0)) ? box_len - rem_rsp.rem : rem_rsp.rem;
    axis_gap = ((box_len - fold_d) < fold_d) ? box_len - fold_d : fold_d;

    unique case (state_q)
      vfu_pkg::S_MUL_X: begin
        mul_a = c_q;
        mul_b = $signed({2'b00, speed_q});
      end
      vfu_pkg::S_MUL_Y: begin
        mul_a = s_q;
        mul_b = $signed({2'b00, speed_q});
      end
      vfu_pkg::S_SQ_X: begin
        mul_a = $signed({17'd0, dx_q});
        mul_b = $signed({1'b0, dx_q});
      end
      vfu_pkg::S_SQ_Y: begin
        mul_a = $signed({17'd0, dy_q});
        mul_b = $signed({1'b0, dy_q});
      end
      default: begin
        mul_a = 34'(noise_q);
        mul_b = $signed({2'b00, nscale_q});
      end
    endcase
    prod   = mul_a * mul_b;
    sq_sum = mul_q[32:0] + prod[32:0];
    hit    = sq_sum < {1'b0, radius_q};

    z_rnd = atan_z_q + 32'h0000_8000;
    newh  = z_rnd[31:16] + mul_q[30:15];
  end

  always_comb begin
    in_if.ready = (state_q == vfu_pkg::S_IDLE);
    out_if.valid = (state_q == vfu_pkg::S_OUT);
    out_if.out_x = o_x_q;
    out_if.out_y = o_y_q;
    out_if.out_heading = o_h_q;
    out_if.neighbour_count = o_cnt_q;
    out_if.status = o_st_q;

    rd_addr = (state_q == vfu_pkg::S_IDLE) ? {bank_q, in_if.index} : {bank_q, j_q[IW-1:0]};
    wr_en   = (accept && (in_if.cmd == vfu_pkg::CMD_LOAD) && in_range) ||
              (state_q == vfu_pkg::S_WRITE);
    if (state_q == vfu_pkg::S_WRITE) begin
      wr_addr = {~bank_q, idx_q};
      wr_data = '{x: nx_q, y: ny_q, h: newh};
    end else begin
      wr_addr = {bank_q, in_if.index};
      wr_data = '{x: in_if.pos_x, y: in_if.pos_y, h: in_if.heading};
    end

    cord_req.start = (state_q == vfu_pkg::S_SELF_LAT) ||
                     ((state_q == vfu_pkg::S_SQ_Y) && hit) ||
                     (state_q == vfu_pkg::S_NOISE);
    cord_req.vec = (state_q == vfu_pkg::S_NOISE);
    cord_req.x = sumc_q;
    cord_req.y = sums_q;
    cord_req.z = (state_q == vfu_pkg::S_SELF_LAT) ? {rd_data.h, 16'h0} : {nb_h_q, 16'h0};

    rem_req.start = (state_q == vfu_pkg::S_WX_ST) || (state_q == vfu_pkg::S_WY_ST) ||
                    (state_q == vfu_pkg::S_NB_LAT) ||
                    ((state_q == vfu_pkg::S_NB_DX) && rem_rsp.done);
    rem_req.dividend = sval[17] ? 17'(-sval) : sval[16:0];
    rem_req.divisor  = box_len;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfu_pkg::S_IDLE: begin
        if (accept) begin
          if (in_if.cmd == vfu_pkg::CMD_SWAP || !in_range || in_if.cmd == vfu_pkg::CMD_LOAD) begin
            state_d = vfu_pkg::S_OUT;
          end else if (in_if.cmd == vfu_pkg::CMD_READ) begin
            state_d = vfu_pkg::S_RD;
          end else begin
            state_d = vfu_pkg::S_SELF_LAT;
          end
        end
      end
      vfu_pkg::S_RD:       state_d = vfu_pkg::S_OUT;
      vfu_pkg::S_OUT:      if (out_if.ready) state_d = vfu_pkg::S_IDLE;
      vfu_pkg::S_SELF_LAT: state_d = vfu_pkg::S_SELF_CS;
      vfu_pkg::S_SELF_CS:  if (cord_rsp.done) state_d = vfu_pkg::S_MUL_X;
      vfu_pkg::S_MUL_X:    state_d = vfu_pkg::S_WX_ST;
      vfu_pkg::S_WX_ST:    state_d = vfu_pkg::S_WX;
      vfu_pkg::S_WX:       if (rem_rsp.done) state_d = vfu_pkg::S_MUL_Y;
      vfu_pkg::S_MUL_Y:    state_d = vfu_pkg::S_WY_ST;
      vfu_pkg::S_WY_ST:    state_d = vfu_pkg::S_WY;
      vfu_pkg::S_WY:       if (rem_rsp.done) state_d = vfu_pkg::S_NB_CHK;
      vfu_pkg::S_NB_CHK: begin
        if (j_q >= n_eff) begin
          state_d = vfu_pkg::S_NOISE;
        end else if (j_q[IW-1:0] != idx_q) begin
          state_d = vfu_pkg::S_NB_LAT;
        end
      end
      vfu_pkg::S_NB_LAT:   state_d = vfu_pkg::S_NB_DX;
      vfu_pkg::S_NB_DX:    if (rem_rsp.done) state_d = vfu_pkg::S_NB_DY;
      vfu_pkg::S_NB_DY:    if (rem_rsp.done) state_d = vfu_pkg::S_SQ_X;
      vfu_pkg::S_SQ_X:     state_d = vfu_pkg::S_SQ_Y;
      vfu_pkg::S_SQ_Y:     state_d = hit ? vfu_pkg::S_NB_CS : vfu_pkg::S_NB_CHK;
      vfu_pkg::S_NB_CS:    if (cord_rsp.done) state_d = vfu_pkg::S_NB_CHK;
      vfu_pkg::S_NOISE:    state_d = vfu_pkg::S_ATAN;
      vfu_pkg::S_ATAN:     if (cord_rsp.done) state_d = vfu_pkg::S_WRITE;
      vfu_pkg::S_WRITE:    state_d = vfu_pkg::S_OUT;
      default:             state_d = vfu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vfu_pkg::S_IDLE;
      bank_q   <= 1'b0;
      pc_q     <= 7'd40;
      box_q    <= 16'd65535;
      speed_q  <= 16'd634;
      radius_q <= 32'd446890000;
      nscale_q <= 16'd0;
      cnt_q    <= '0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vfu_pkg::CFG_PARTICLE_COUNT: pc_q     <= cfg_data_i[6:0];
          vfu_pkg::CFG_BOX_LENGTH:     box_q    <= cfg_data_i[15:0];
          vfu_pkg::CFG_SPEED_STEP:     speed_q  <= cfg_data_i[15:0];
          vfu_pkg::CFG_RADIUS_SQ:      radius_q <= cfg_data_i;
          vfu_pkg::CFG_NOISE_SCALE:    nscale_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (accept && (in_if.cmd == vfu_pkg::CMD_SWAP)) begin
        bank_q <= ~bank_q;
      end
      if ((state_q == vfu_pkg::S_SELF_CS) && cord_rsp.done) begin
        cnt_q <= '0;
      end
      if ((state_q == vfu_pkg::S_WY) && rem_rsp.done) begin
        j_q <= '0;
      end
      if ((state_q == vfu_pkg::S_NB_CHK) && (j_q < n_eff) && (j_q[IW-1:0] == idx_q)) begin
        j_q <= j_q + 1'b1;
      end
      if ((state_q == vfu_pkg::S_SQ_Y) && !hit) begin
        j_q <= j_q + 1'b1;
      end
      if ((state_q == vfu_pkg::S_NB_CS) && cord_rsp.done) begin
        j_q   <= j_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_req.start) begin
      sign_q <= sval[17];
    end
    if ((state_q == vfu_pkg::S_MUL_X) || (state_q == vfu_pkg::S_MUL_Y) ||
        (state_q == vfu_pkg::S_SQ_X) || (state_q == vfu_pkg::S_NOISE)) begin
      mul_q <= prod;
    end
    unique case (state_q)
      vfu_pkg::S_IDLE: begin
        idx_q   <= in_if.index;
        noise_q <= in_if.noise;
        o_cnt_q <= '0;
        o_st_q  <= !in_range && (in_if.cmd != vfu_pkg::CMD_SWAP);
        if ((in_if.cmd == vfu_pkg::CMD_LOAD) && in_range) begin
          o_x_q <= in_if.pos_x;
          o_y_q <= in_if.pos_y;
          o_h_q <= in_if.heading;
        end else begin
          o_x_q <= '0;
          o_y_q <= '0;
          o_h_q <= '0;
        end
      end
      vfu_pkg::S_RD: begin
        o_x_q <= rd_data.x;
        o_y_q <= rd_data.y;
        o_h_q <= rd_data.h;
      end
      vfu_pkg::S_SELF_LAT: begin
        px_q <= rd_data.x;
        py_q <= rd_data.y;
      end
      vfu_pkg::S_SELF_CS: begin
        if (cord_rsp.done) begin
          c_q    <= cord_rsp.x[vfu_pkg::MUL_AW-1:0];
          s_q    <= cord_rsp.y[vfu_pkg::MUL_AW-1:0];
          sumc_q <= cord_rsp.x;
          sums_q <= cord_rsp.y;
        end
      end
      vfu_pkg::S_WX: if (rem_rsp.done) nx_q <= fold_d[15:0];
      vfu_pkg::S_WY: if (rem_rsp.done) ny_q <= fold_d[15:0];
      vfu_pkg::S_NB_LAT: begin
        nb_y_q <= rd_data.y;
        nb_h_q <= rd_data.h;
      end
      vfu_pkg::S_NB_DX: if (rem_rsp.done) dx_q <= axis_gap;
      vfu_pkg::S_NB_DY: if (rem_rsp.done) dy_q <= axis_gap;
      vfu_pkg::S_NB_CS: begin
        if (cord_rsp.done) begin
          sumc_q <= sumc_q + cord_rsp.x;
          sums_q <= sums_q + cord_rsp.y;
        end
      end
      vfu_pkg::S_ATAN: if (cord_rsp.done) atan_z_q <= cord_rsp.z;
      vfu_pkg::S_WRITE: begin
        o_x_q   <= nx_q;
        o_y_q   <= ny_q;
        o_h_q   <= newh;
        o_cnt_q <= cnt_q[IW-1:0];
        o_st_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  `VFU_ASSERT_NEVER(a_in_out_overlap, in_if.ready && out_if.valid)
  `VFU_ASSERT(a_cnt_bounded, cnt_q <= j_q)
  `VFU_ASSERT(a_back_to_idle, out_if.valid && out_if.ready |=> in_if.ready)
  `VFU_ASSERT(a_cordic_free, cord_req.start |-> !cord_rsp.busy)
  `VFU_ASSERT(a_rem_free, rem_req.start |-> !rem_rsp.busy)

endmodule
